/* rtl/wtps_pkg.sv */
// wtps_pkg: shared types, constants and functions of the word table prefix search unit
// used by wtps_cmp and word_table_prefix_search_unit; no dependencies
package wtps_pkg;

    localparam int WORD_COUNT     = 2048;
    localparam int MAX_MATCHES    = 8;
    localparam int MAX_WORD_CHARS = 8;

    localparam int ADDR_W  = $clog2(WORD_COUNT);
    localparam int INDEX_W = 11;
    localparam int TEXT_W  = 64;
    localparam int LEN_W   = 4;
    localparam int NUM_W   = 4;
    localparam int CHARS   = TEXT_W / 8;

    typedef enum logic [1:0] {
        FN_LOAD   = 2'd0,
        FN_PREFIX = 2'd1,
        FN_EXACT  = 2'd2,
        FN_READ   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic [TEXT_W-1:0] text;
        logic [LEN_W-1:0]  len;
        logic              exact;
    } query_t;

    typedef struct packed {
        logic [TEXT_W-1:0] text;
        logic [LEN_W-1:0]  len;
    } norm_t;

    function automatic logic [7:0] fold(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    // keep chars before the first zero byte, up to the given length
    function automatic norm_t normalise(input logic [TEXT_W-1:0] v, input logic [LEN_W-1:0] n);
        norm_t      r;
        logic       run;
        logic [7:0] b;
        r   = '0;
        run = 1'b1;
        for (int i = 0; i < CHARS; i++)
        begin
            b = v[8*i +: 8];
            if (i >= MAX_WORD_CHARS || LEN_W'(i) >= n || b == 8'd0)
            begin
                run = 1'b0;
            end
            if (run)
            begin
                r.text[8*i +: 8] = b;
                r.len            = LEN_W'(i + 1);
            end
        end
        return r;
    endfunction

endpackage

/* rtl/wtps_ram.sv */
// wtps_ram: generic simple dual-port ram, one write port and one registered read port
// no dependencies
module wtps_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/wtps_cmp.sv */
// wtps_cmp: shared word compare unit, case-folded prefix match or case-sensitive exact match of one table word
// depends on wtps_pkg
module wtps_cmp (
    input  logic [wtps_pkg::TEXT_W-1:0] word,
    input  wtps_pkg::query_t            query,
    output logic                        hit
);

    import wtps_pkg::*;

    logic prefix_hit;

    always_comb
    begin
        prefix_hit = 1'b1;
        for (int j = 0; j < CHARS; j++)
        begin
            if (LEN_W'(j) < query.len && fold(word[8*j +: 8]) != fold(query.text[8*j +: 8]))
            begin
                prefix_hit = 1'b0;
            end
        end
    end

    // stored words are already normalised, so exact match is a plain equality
    assign hit = query.exact ? (word == query.text) : prefix_hit;

endmodule

/* rtl/word_table_prefix_search_unit.sv */
// word_table_prefix_search_unit: top level, sequencer and result register around the table
// depends on wtps_pkg, wtps_ram, wtps_cmp
//
// Usage: commands arrive on the s_axis channel, results leave on m_axis.
// s_axis_tuser selects load, prefix search, exact lookup or read; tdata carries
// index, text and text_length. A load gives no beat and leaves the unit idle. A read
// gives one beat: the ram read data is registered, then moved into the result
// register once it is free. A search walks the table one entry per cycle while it
// is not held, through the shared compare unit, reading the ram port once per entry;
// an exact hit ends the walk early, a prefix search ends after MAX_MATCHES matches.
// A prefix search gives one beat per match, the final one with tlast set; no
// match or an empty text gives one not-found beat. s_axis_tready is high only
// while no command is in progress; a new command can be taken while the last
// result beat still waits. When the receiver stalls and a prefix hit must hand on
// an earlier match, the walk holds at the current entry until the result register
// frees up. Reset clears the state, the pending-match flag and the result valid flag;
// the table is not cleared and must be loaded before it is read or searched.
module word_table_prefix_search_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // index[10:0], text[74:11], text_length[78:75]
    input  logic [1:0]  s_axis_tuser,   // func[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // found_index[10:0], match_number[14:11], word_text[78:15]
    output logic        m_axis_tuser,   // found
    output logic        m_axis_tlast
);

    import wtps_pkg::*;

    state_t state_reg, state_next;

    query_t              query_reg, query_next;
    logic [ADDR_W-1:0]   chk_idx_reg, chk_idx_next;
    logic                pend_vld_reg, pend_vld_next;
    logic [ADDR_W-1:0]   pend_idx_reg, pend_idx_next;
    logic [NUM_W-1:0]    pend_num_reg, pend_num_next;
    logic                rd_ok_reg, rd_ok_next;

    logic                out_valid_reg;
    logic                out_found_reg, out_found_next;
    logic [INDEX_W-1:0]  out_idx_reg, out_idx_next;
    logic [NUM_W-1:0]    out_num_reg, out_num_next;
    logic [TEXT_W-1:0]   out_word_reg, out_word_next;
    logic                out_last_reg, out_last_next;
    logic                load_out;

    logic                ram_we;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [TEXT_W-1:0]   ram_rdata;
    logic                hit;

    func_t               in_func;
    logic [INDEX_W-1:0]  in_index;
    logic [TEXT_W-1:0]   in_text;
    logic [LEN_W-1:0]    in_len;
    norm_t               in_norm;
    logic                in_range;
    logic                accept;

    logic                out_free;
    logic                last_entry;
    logic [NUM_W-1:0]    new_num;
    logic                stall;
    logic                scan_done;

    assign in_index = s_axis_tdata[10:0];
    assign in_text  = s_axis_tdata[74:11];
    assign in_len   = s_axis_tdata[78:75];
    assign in_func  = func_t'(s_axis_tuser);
    assign in_norm  = normalise(in_text, in_len);
    assign in_range = 32'(in_index) < WORD_COUNT;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign last_entry = (chk_idx_reg == ADDR_W'(WORD_COUNT - 1));
    assign new_num    = pend_num_reg + NUM_W'(1);
    assign stall      = !query_reg.exact && hit && pend_vld_reg && !out_free;
    assign scan_done  = (query_reg.exact && hit)
                     || (!query_reg.exact && hit && !stall && new_num == NUM_W'(MAX_MATCHES))
                     || (!stall && last_entry);

    assign ram_we = accept && in_func == FN_LOAD && in_range;

    wtps_ram #(
        .WIDTH (TEXT_W),
        .DEPTH (WORD_COUNT)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (in_index[ADDR_W-1:0]),
        .wdata (in_norm.text),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    wtps_cmp u_cmp (
        .word  (ram_rdata),
        .query (query_reg),
        .hit   (hit)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_func)
                        FN_PREFIX, FN_EXACT:
                        begin
                            state_next = (in_norm.len == '0) ? ST_FLUSH : ST_SCAN;
                        end
                        FN_READ:
                        begin
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_READ, ST_FLUSH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        query_next     = query_reg;
        chk_idx_next   = chk_idx_reg;
        pend_vld_next  = pend_vld_reg;
        pend_idx_next  = pend_idx_reg;
        pend_num_next  = pend_num_reg;
        rd_ok_next     = rd_ok_reg;
        ram_re         = 1'b0;
        ram_raddr      = chk_idx_reg + ADDR_W'(1);
        load_out       = 1'b0;
        out_found_next = out_found_reg;
        out_idx_next   = out_idx_reg;
        out_num_next   = out_num_reg;
        out_word_next  = out_word_reg;
        out_last_next  = out_last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_func != FN_LOAD)
                begin
                    query_next.text  = in_norm.text;
                    query_next.len   = in_norm.len;
                    query_next.exact = (in_func == FN_EXACT);
                    pend_vld_next    = 1'b0;
                    pend_num_next    = '0;
                    rd_ok_next       = in_range;
                    ram_re           = 1'b1;
                    if (in_func == FN_READ)
                    begin
                        chk_idx_next = in_index[ADDR_W-1:0];
                        ram_raddr    = in_index[ADDR_W-1:0];
                    end
                    else
                    begin
                        chk_idx_next = '0;
                        ram_raddr    = '0;
                    end
                end
            end
            ST_SCAN:
            begin
                if (hit && !stall)
                begin
                    if (!query_reg.exact && pend_vld_reg)
                    begin
                        load_out       = 1'b1;
                        out_found_next = 1'b1;
                        out_idx_next   = INDEX_W'(pend_idx_reg);
                        out_num_next   = pend_num_reg;
                        out_word_next  = '0;
                        out_last_next  = 1'b0;
                    end
                    pend_vld_next = 1'b1;
                    pend_idx_next = chk_idx_reg;
                    pend_num_next = query_reg.exact ? NUM_W'(1) : new_num;
                end
                if (!stall && !scan_done)
                begin
                    ram_re       = 1'b1;
                    chk_idx_next = chk_idx_reg + ADDR_W'(1);
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    load_out       = 1'b1;
                    out_found_next = rd_ok_reg;
                    out_idx_next   = rd_ok_reg ? INDEX_W'(chk_idx_reg) : '0;
                    out_num_next   = '0;
                    out_word_next  = rd_ok_reg ? ram_rdata : '0;
                    out_last_next  = 1'b1;
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    load_out       = 1'b1;
                    out_found_next = pend_vld_reg;
                    out_idx_next   = pend_vld_reg ? INDEX_W'(pend_idx_reg) : '0;
                    out_num_next   = pend_vld_reg ? pend_num_reg : '0;
                    out_word_next  = '0;
                    out_last_next  = 1'b1;
                end
            end
            default:
            begin
                load_out = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            pend_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pend_vld_reg <= pend_vld_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        query_reg     <= query_next;
        chk_idx_reg   <= chk_idx_next;
        pend_idx_reg  <= pend_idx_next;
        pend_num_reg  <= pend_num_next;
        rd_ok_reg     <= rd_ok_next;
        out_found_reg <= out_found_next;
        out_idx_reg   <= out_idx_next;
        out_num_reg   <= out_num_next;
        out_word_reg  <= out_word_next;
        out_last_reg  <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_word_reg, out_num_reg, out_idx_reg};
    assign m_axis_tuser  = out_found_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

/* tb/sv/word_table_prefix_search_unit_test.sv */
// word_table_prefix_search_unit_test: self-checking bench for the word table prefix search unit
// fills the table, runs a directed table and random traffic, checks every result beat
// depends on wtps_pkg and word_table_prefix_search_unit
module word_table_prefix_search_unit_test;
    import wtps_pkg::*;

    localparam int RANDOM_ITEMS  = 270;
    localparam int HOLD_CYCLES   = 5000;
    localparam int DRAIN_CYCLES  = 2100;
    localparam int HOLD_AT       = 100;
    localparam int PAUSE_AT      = 180;
    localparam int QUIET_AT      = 230;
    localparam int DIRECTED_ROWS = 25;
    localparam int ROW_W         = $clog2(DIRECTED_ROWS);
    localparam int HIT_W         = $clog2(MAX_MATCHES);

    typedef struct packed {
        func_t       func;
        logic [10:0] index;
        logic [63:0] text;
        logic [3:0]  len;
    } cmd_t;

    typedef struct packed {
        logic        found;
        logic [10:0] found_index;
        logic [3:0]  match_number;
        logic [63:0] word_text;
        logic        last;
    } res_t;

    typedef struct packed {
        cmd_t cmd;
        logic lit;
        res_t want;
    } row_t;

    localparam res_t NOT_FOUND = '{1'b0, 11'd0, 4'd0, 64'd0, 1'b1};
    localparam res_t NOTHING   = '0;

    localparam row_t DIRECTED [DIRECTED_ROWS] = '{
        '{'{FN_LOAD,   11'd0,    64'hFFFF_FFFF_FFFF_FFFF, 4'd8},  1'b0, NOTHING},
        '{'{FN_READ,   11'd0,    64'd0,                   4'd0},  1'b1,
            '{1'b1, 11'd0, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1}},
        '{'{FN_LOAD,   11'd2047, 64'h0000_0000_0000_6241, 4'd2},  1'b0, NOTHING},
        '{'{FN_READ,   11'd2047, 64'd0,                   4'd0},  1'b1,
            '{1'b1, 11'd2047, 4'd0, 64'h0000_0000_0000_6241, 1'b1}},
        '{'{FN_LOAD,   11'd1,    64'h0000_0000_0000_0041, 4'd0},  1'b0, NOTHING},
        '{'{FN_READ,   11'd1,    64'd0,                   4'd0},  1'b1,
            '{1'b1, 11'd1, 4'd0, 64'd0, 1'b1}},
        '{'{FN_LOAD,   11'd2,    64'h4847_4645_4443_4241, 4'd15}, 1'b0, NOTHING},
        '{'{FN_READ,   11'd2,    64'd0,                   4'd0},  1'b1,
            '{1'b1, 11'd2, 4'd0, 64'h4847_4645_4443_4241, 1'b1}},
        '{'{FN_LOAD,   11'd3,    64'h0000_4444_0043_4241, 4'd6},  1'b0, NOTHING},
        '{'{FN_READ,   11'd3,    64'd0,                   4'd0},  1'b1,
            '{1'b1, 11'd3, 4'd0, 64'h0000_0000_0043_4241, 1'b1}},
        '{'{FN_LOAD,   11'd4,    64'h1122_3344_5566_7788, 4'd4},  1'b0, NOTHING},
        '{'{FN_READ,   11'd4,    64'd0,                   4'd0},  1'b1,
            '{1'b1, 11'd4, 4'd0, 64'h0000_0000_5566_7788, 1'b1}},
        '{'{FN_LOAD,   11'd5,    64'h0000_0000_7B60_5B40, 4'd4},  1'b0, NOTHING},
        '{'{FN_PREFIX, 11'd0,    64'h0000_0000_7B60_5B40, 4'd4},  1'b0, NOTHING},
        '{'{FN_PREFIX, 11'd0,    64'h0000_0000_0000_6161, 4'd0},  1'b1, NOT_FOUND},
        '{'{FN_PREFIX, 11'd0,    64'h0000_0000_0000_6100, 4'd2},  1'b1, NOT_FOUND},
        '{'{FN_EXACT,  11'd0,    64'h0000_0000_0000_6241, 4'd0},  1'b1, NOT_FOUND},
        '{'{FN_EXACT,  11'd0,    64'h4847_4645_4443_4241, 4'd8},  1'b0, NOTHING},
        '{'{FN_EXACT,  11'd0,    64'h6867_6665_6463_6261, 4'd8},  1'b0, NOTHING},
        '{'{FN_EXACT,  11'd2047, 64'hDEAD_0000_0000_6241, 4'd2},  1'b0, NOTHING},
        '{'{FN_PREFIX, 11'd0,    64'h0000_0000_0000_4261, 4'd2},  1'b0, NOTHING},
        '{'{FN_PREFIX, 11'd0,    64'hFFFF_FFFF_FFFF_FFFF, 4'd8},  1'b0, NOTHING},
        '{'{FN_PREFIX, 11'd0,    64'h0000_0000_0000_5A7A, 4'd2},  1'b0, NOTHING},
        '{'{FN_PREFIX, 11'd0,    64'h0000_0000_0000_0061, 4'd15}, 1'b0, NOTHING},
        '{'{FN_READ,   11'd1023, 64'd0,                   4'd0},  1'b0, NOTHING}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;   // index[10:0], text[74:11], text_length[78:75]
    logic [1:0]  s_axis_tuser = '0;   // func[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;        // found_index[10:0], match_number[14:11], word_text[78:15]
    logic        m_axis_tuser;        // found
    logic        m_axis_tlast;

    logic [63:0] word_mem [WORD_COUNT];
    res_t        pending_results [$];
    res_t        head_beat;
    int          error_count = 0;
    int          beat_count = 0;
    int          load_count = 0;
    int          prefix_count = 0;
    int          exact_count = 0;
    int          read_count = 0;
    logic        quiet_phase = 1'b0;
    logic        hold_request = 1'b0;

    word_table_prefix_search_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #80_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic logic [7:0] lower_char(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            return c + 8'd32;
        end
        return c;
    endfunction

    // chars before the first zero byte, at most n of them and at most MAX_WORD_CHARS
    function automatic logic [63:0] trim_text(input logic [63:0] v, input logic [3:0] n,
                                              output int cnt);
        logic [63:0] r;
        logic        run;
        r   = '0;
        cnt = 0;
        run = 1'b1;
        for (int i = 0; i < MAX_WORD_CHARS; i++)
        begin
            if (i >= n || v[8*i +: 8] == 8'd0)
            begin
                run = 1'b0;
            end
            if (run)
            begin
                r[8*i +: 8] = v[8*i +: 8];
                cnt         = i + 1;
            end
        end
        return r;
    endfunction

    function automatic logic starts_with(input logic [63:0] w, input logic [63:0] p,
                                         input int plen);
        for (int j = 0; j < plen; j++)
        begin
            if (lower_char(w[8*j +: 8]) != lower_char(p[8*j +: 8]))
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic void predict_command(input cmd_t c);
        logic [63:0] t;
        int          tl;
        int          hits;
        int          hit_idx [MAX_MATCHES];
        res_t        r;
        t    = trim_text(c.text, c.len, tl);
        hits = 0;
        r    = NOT_FOUND;
        case (c.func)
            FN_LOAD:
            begin
                word_mem[c.index] = t;
            end
            FN_PREFIX:
            begin
                if (tl > 0)
                begin
                    for (int i = 0; i < WORD_COUNT && hits < MAX_MATCHES; i++)
                    begin
                        if (starts_with(word_mem[ADDR_W'(i)], t, tl))
                        begin
                            hit_idx[HIT_W'(hits)] = i;
                            hits++;
                        end
                    end
                end
                for (int k = 0; k < hits; k++)
                begin
                    r = '{1'b1, 11'(hit_idx[HIT_W'(k)]), 4'(k + 1), 64'd0, k == hits - 1};
                    pending_results.push_back(r);
                end
                if (hits == 0)
                begin
                    pending_results.push_back(NOT_FOUND);
                end
            end
            FN_EXACT:
            begin
                if (tl > 0)
                begin
                    for (int i = 0; i < WORD_COUNT; i++)
                    begin
                        if (hits == 0 && word_mem[ADDR_W'(i)] == t)
                        begin
                            hits = 1;
                            r    = '{1'b1, 11'(i), 4'd1, 64'd0, 1'b1};
                        end
                    end
                end
                pending_results.push_back(r);
            end
            default:
            begin
                r = '{1'b1, c.index, 4'd0, word_mem[c.index], 1'b1};
                pending_results.push_back(r);
            end
        endcase
    endfunction

    // short word over the letters a to c in both cases, now and then any nonzero byte
    function automatic logic [63:0] pick_word(output logic [3:0] len_field);
        logic [63:0] w;
        logic [7:0]  c;
        int          n;
        w = '0;
        n = $urandom_range(0, 8);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                c = 8'($urandom_range(1, 255));
            end
            else
            begin
                c = 8'h61 + 8'($urandom_range(0, 2));
                if ($urandom_range(0, 1) == 1)
                begin
                    c = c - 8'd32;
                end
            end
            w[8*i +: 8] = c;
        end
        case ($urandom_range(0, 2))
            0:
            begin
                len_field = 4'(n);
            end
            1:
            begin
                len_field = 4'(n);
                for (int i = n; i < 8; i++)
                begin
                    w[8*i +: 8] = 8'($urandom);
                end
            end
            default:
            begin
                len_field = 4'($urandom_range(n, 15));
                for (int i = n + 1; i < 8; i++)
                begin
                    w[8*i +: 8] = 8'($urandom);
                end
            end
        endcase
        return w;
    endfunction

    // first n chars of w, letters case-flipped at random when asked, junk or zeros above
    function automatic logic [63:0] dress_text(input logic [63:0] w, input int n,
                                               input logic flip);
        logic [63:0] r;
        logic [7:0]  b;
        logic        junk;
        r    = '0;
        junk = ($urandom_range(0, 1) == 1);
        for (int i = 0; i < 8; i++)
        begin
            b = w[8*i +: 8];
            if (i >= n)
            begin
                b = junk ? 8'($urandom) : 8'd0;
            end
            else if (flip && $urandom_range(0, 1) == 1 &&
                     ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A)))
            begin
                b = b ^ 8'h20;
            end
            r[8*i +: 8] = b;
        end
        return r;
    endfunction

    function automatic cmd_t random_command();
        cmd_t        c;
        logic [63:0] w;
        logic [3:0]  lf;
        int          wl;
        int          sel;
        int          plen;
        sel     = $urandom_range(0, 99);
        c.index = 11'($urandom_range(0, WORD_COUNT - 1));
        c.text  = {$urandom, $urandom};
        c.len   = 4'($urandom_range(0, 15));
        w       = trim_text(word_mem[ADDR_W'($urandom_range(0, WORD_COUNT - 1))], 4'd8, wl);
        if (sel < 35)
        begin
            c.func = FN_LOAD;
            if ($urandom_range(0, 4) != 0)
            begin
                c.text = pick_word(lf);
                c.len  = lf;
            end
        end
        else if (sel < 60)
        begin
            c.func = FN_PREFIX;
            if ($urandom_range(0, 3) != 0)
            begin
                plen   = (wl == 0) ? 0 : $urandom_range(1, wl);
                c.text = dress_text(w, plen, 1'b1);
                c.len  = 4'(plen);
            end
        end
        else if (sel < 80)
        begin
            c.func = FN_EXACT;
            sel    = $urandom_range(0, 9);
            if (sel < 9)
            begin
                c.text = dress_text(w, wl, sel >= 7);
                c.len  = 4'(wl);
            end
        end
        else
        begin
            c.func = FN_READ;
        end
        return c;
    endfunction

    task automatic send_command(input cmd_t c, input logic use_lit, input res_t lit);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= c.func;
        s_axis_tdata  <= {1'b0, c.len, c.text, c.index};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        if (use_lit && c.func != FN_LOAD)
        begin
            pending_results.push_back(lit);
        end
        else
        begin
            predict_command(c);
        end
        case (c.func)
            FN_LOAD:   load_count++;
            FN_PREFIX: prefix_count++;
            FN_EXACT:  exact_count++;
            default:   read_count++;
        endcase
        if (!quiet_phase && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
        begin
            report_mismatch(what, got, want);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            beat_count++;
            if (pending_results.size() == 0)
            begin
                report_mismatch("beat with nothing pending", m_axis_tdata[63:0], 64'd0);
            end
            else
            begin
                head_beat = pending_results.pop_front();
                check_field("found", 64'(m_axis_tuser), 64'(head_beat.found));
                check_field("found_index", 64'(m_axis_tdata[10:0]),
                            64'(head_beat.found_index));
                check_field("match_number", 64'(m_axis_tdata[14:11]),
                            64'(head_beat.match_number));
                check_field("word_text", m_axis_tdata[78:15], head_beat.word_text);
                check_field("last", 64'(m_axis_tlast), 64'(head_beat.last));
            end
        end
    end

    initial
    begin
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            if (hold_request)
            begin
                m_axis_tready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++)
                begin
                    @(posedge clk);
                end
                hold_request = 1'b0;
            end
            else if (!quiet_phase && $urandom_range(0, 7) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        cmd_t       c;
        logic [3:0] lf;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every entry is written before any search or read
        for (int i = 0; i < WORD_COUNT; i++)
        begin
            c.func  = FN_LOAD;
            c.index = 11'(i);
            c.text  = pick_word(lf);
            c.len   = lf;
            send_command(c, 1'b0, NOTHING);
        end

        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            send_command(DIRECTED[ROW_W'(r)].cmd, DIRECTED[ROW_W'(r)].lit,
                         DIRECTED[ROW_W'(r)].want);
        end

        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k == HOLD_AT)
            begin
                hold_request = 1'b1;
            end
            if (k == PAUSE_AT)
            begin
                s_axis_tvalid <= 1'b0;
                while (pending_results.size() != 0)
                begin
                    @(posedge clk);
                end
            end
            if (k == QUIET_AT)
            begin
                quiet_phase = 1'b1;
            end
            send_command(random_command(), 1'b0, NOTHING);
        end
        s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d loads, %0d prefix searches, %0d exact lookups, %0d reads",
                 load_count, prefix_count, exact_count, read_count);
        $display("%0d result beats checked, with a long receiver hold and a full drain pause",
                 beat_count);
        if (error_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
